### hdl/hgpc_pkg.sv
// Shared types and constants for the HSV gradient position color block.
package hgpc_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_HUE  = 3'd0,
		REG_START_SAT  = 3'd1,
		REG_START_VAL  = 3'd2,
		REG_END_HUE    = 3'd3,
		REG_END_SAT    = 3'd4,
		REG_END_VAL    = 3'd5,
		REG_REFLECT    = 3'd6,
		REG_BRIGHTNESS = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] start_hue;
		logic [7:0] start_sat;
		logic [7:0] start_val;
		logic [7:0] end_hue;
		logic [7:0] end_sat;
		logic [7:0] end_val;
		logic       reflect_mode;
		logic [7:0] global_brightness;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		start_hue:         8'd0,
		start_sat:         8'd255,
		start_val:         8'd255,
		end_hue:           8'd128,
		end_sat:           8'd255,
		end_val:           8'd255,
		reflect_mode:      1'b0,
		global_brightness: 8'd255
	};

	// Hue offset sign and base, carried alongside the blend stages
	typedef struct packed {
		logic [7:0] a_hue;
		logic       neg;
	} hue_base_t;

	// Position and endpoint deltas after the first stage
	typedef struct packed {
		logic [7:0] n;
		hue_base_t  hue;
		logic [7:0] hue_d;
		logic [7:0] a_sat;
		logic [7:0] sat_d;
		logic       sat_neg;
		logic [7:0] a_val;
		logic [7:0] val_d;
		logic       val_neg;
	} prep_t;

	// Per-stage load enables
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} stage_en_t;

	// Load enables of a two-stage divider
	typedef struct packed {
		logic a;
		logic b;
	} div_en_t;

endpackage

### hdl/hgpc_if.sv
// Stream interfaces for LED coordinates in and HSV colors out.
interface hgpc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] led_x;

	modport source (output valid, output led_x, input ready);
	modport sink (input valid, input led_x, output ready);
endinterface

interface hgpc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_hue;
	logic [7:0] out_sat;
	logic [7:0] out_val;

	modport source (output valid, output out_hue, output out_sat, output out_val, input ready);
	modport sink (input valid, input out_hue, input out_sat, input out_val, output ready);
endinterface

### hdl/hgpc_cfg_regs.sv
// Configuration register file for the gradient endpoints, mode and brightness.
module hgpc_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             we,
	input  logic [hgpc_pkg::CFG_IDX_W-1:0]   index,
	input  logic [hgpc_pkg::CFG_DATA_W-1:0]  wdata,
	output hgpc_pkg::cfg_t                   cfg_q
);
	import hgpc_pkg::*;

	// Write one register per enabled cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (we) begin
			unique case (cfg_reg_t'(index))
				REG_START_HUE:  cfg_q.start_hue <= wdata;
				REG_START_SAT:  cfg_q.start_sat <= wdata;
				REG_START_VAL:  cfg_q.start_val <= wdata;
				REG_END_HUE:    cfg_q.end_hue <= wdata;
				REG_END_SAT:    cfg_q.end_sat <= wdata;
				REG_END_VAL:    cfg_q.end_val <= wdata;
				REG_REFLECT:    cfg_q.reflect_mode <= wdata[0];
				REG_BRIGHTNESS: cfg_q.global_brightness <= wdata;
			endcase
		end
	end

endmodule

### hdl/hgpc_prep.sv
// Stage 1: clamp the coordinate, fold for reflect mode, pick endpoints and deltas.
module hgpc_prep #(
	parameter int X_SPAN = 224
) (
	input  logic            clk,
	input  logic            en,
	input  logic [7:0]      led_x,
	input  hgpc_pkg::cfg_t  cfg,
	output hgpc_pkg::prep_t prep_s1
);
	import hgpc_pkg::*;

	localparam logic [7:0] SPAN  = 8'(X_SPAN);
	localparam logic [8:0] SPAN9 = 9'(X_SPAN);

	logic [7:0] xs;
	logic [8:0] twice;
	logic       swap;
	logic [7:0] a_h, b_h, a_s, b_s, a_v, b_v;
	logic [7:0] cw, ccw;
	prep_t      nxt;

	// Fold position and choose the endpoint order
	always_comb begin
		xs    = (led_x > SPAN) ? SPAN : led_x;
		twice = {xs, 1'b0};
		swap  = cfg.reflect_mode && (twice > SPAN9);
		if (!cfg.reflect_mode) begin
			nxt.n = xs;
		end else if (!swap) begin
			nxt.n = twice[7:0];
		end else begin
			nxt.n = 8'(twice - SPAN9);
		end

		a_h = swap ? cfg.end_hue : cfg.start_hue;
		b_h = swap ? cfg.start_hue : cfg.end_hue;
		a_s = swap ? cfg.end_sat : cfg.start_sat;
		b_s = swap ? cfg.start_sat : cfg.end_sat;
		a_v = swap ? cfg.end_val : cfg.start_val;
		b_v = swap ? cfg.start_val : cfg.end_val;

		// Both hue distances use a 255 wrap
		if (a_h >= b_h) begin
			cw  = b_h - a_h - 8'd1;
			ccw = a_h - b_h;
		end else begin
			cw  = b_h - a_h;
			ccw = a_h - b_h - 8'd1;
		end
		nxt.hue.a_hue = a_h;
		nxt.hue.neg   = !(cw < ccw);
		nxt.hue_d     = nxt.hue.neg ? ccw : cw;

		nxt.a_sat   = a_s;
		nxt.sat_neg = b_s < a_s;
		nxt.sat_d   = nxt.sat_neg ? (a_s - b_s) : (b_s - a_s);

		nxt.a_val   = a_v;
		nxt.val_neg = b_v < a_v;
		nxt.val_d   = nxt.val_neg ? (a_v - b_v) : (b_v - a_v);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prep_s1 <= nxt;
		end
	end

endmodule

### hdl/hgpc_blend.sv
// Stages 2-4: position products, blend numerators and brightness scaling.
module hgpc_blend #(
	parameter int X_SPAN = 224
) (
	input  logic                  clk,
	input  hgpc_pkg::stage_en_t   en,
	input  hgpc_pkg::prep_t       prep_s1,
	input  logic [7:0]            brightness,
	output logic [15:0]           hprod_s2,
	output logic [15:0]           snum_s3,
	output logic [23:0]           vmul_s4,
	output hgpc_pkg::hue_base_t   hbase_s4
);
	import hgpc_pkg::*;

	localparam logic [15:0] SPAN16 = 16'(X_SPAN);

	logic [15:0] sprod_s2, vprod_s2;
	logic [7:0]  a_sat_s2, a_val_s2;
	logic        sneg_s2, vneg_s2;
	hue_base_t   hbase_s2, hbase_s3;
	logic [15:0] vnum_s3;
	logic [15:0] sbase, vbase;

	// Stage 2: position times each delta
	always_ff @(posedge clk) begin
		if (en.s2) begin
			hprod_s2 <= {8'd0, prep_s1.n} * {8'd0, prep_s1.hue_d};
			sprod_s2 <= {8'd0, prep_s1.n} * {8'd0, prep_s1.sat_d};
			vprod_s2 <= {8'd0, prep_s1.n} * {8'd0, prep_s1.val_d};
			a_sat_s2 <= prep_s1.a_sat;
			a_val_s2 <= prep_s1.a_val;
			sneg_s2  <= prep_s1.sat_neg;
			vneg_s2  <= prep_s1.val_neg;
			hbase_s2 <= prep_s1.hue;
		end
	end

	// Stage 3: start term plus or minus the product
	always_comb begin
		sbase = {8'd0, a_sat_s2} * SPAN16;
		vbase = {8'd0, a_val_s2} * SPAN16;
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			snum_s3  <= sneg_s2 ? (sbase - sprod_s2) : (sbase + sprod_s2);
			vnum_s3  <= vneg_s2 ? (vbase - vprod_s2) : (vbase + vprod_s2);
			hbase_s3 <= hbase_s2;
		end
	end

	// Stage 4: scale the value numerator by brightness
	always_ff @(posedge clk) begin
		if (en.s4) begin
			vmul_s4  <= {8'd0, vnum_s3} * {16'd0, brightness};
			hbase_s4 <= hbase_s3;
		end
	end

endmodule

### hdl/hgpc_div_const.sv
// Two-stage floor division by a constant: reciprocal estimate, then one correction.
module hgpc_div_const #(
	parameter int DIVISOR = 224,
	parameter int NUM_W   = 16,
	parameter int Q_W     = 8
) (
	input  logic                  clk,
	input  hgpc_pkg::div_en_t     en,
	input  logic [NUM_W-1:0]      num,
	output logic [Q_W-1:0]        quo_q
);
	import hgpc_pkg::*;

	// Reciprocal scaled by 2^NUM_W; estimate is low by at most one
	localparam logic [NUM_W-1:0] RECIP = NUM_W'((64'd1 << NUM_W) / DIVISOR);
	localparam logic [NUM_W-1:0] DIV_C = NUM_W'(DIVISOR);

	logic [2*NUM_W-1:0] prod;
	logic [Q_W-1:0]     est_a_q;
	logic [NUM_W-1:0]   num_a_q;
	logic [NUM_W-1:0]   qd;
	logic [NUM_W-1:0]   rem;

	// Estimate quotient
	assign prod = {{NUM_W{1'b0}}, num} * {{NUM_W{1'b0}}, RECIP};

	always_ff @(posedge clk) begin
		if (en.a) begin
			est_a_q <= prod[NUM_W +: Q_W];
			num_a_q <= num;
		end
	end

	// Bump the estimate when the remainder still holds a divisor
	always_comb begin
		qd  = {{(NUM_W-Q_W){1'b0}}, est_a_q} * DIV_C;
		rem = num_a_q - qd;
	end

	always_ff @(posedge clk) begin
		if (en.b) begin
			quo_q <= est_a_q + Q_W'(rem >= DIV_C);
		end
	end

endmodule

### hdl/hsv_gradient_position_color.sv
// An accepted led_x passes through the six-stage pipeline to the output register;
// it holds one item per stage and takes one item per cycle while the output moves.
// A stalled output holds the full stages behind it; empty upstream stages take items.
// Reset clears each stage valid bit and returns config registers to their defaults.
// The value path sets the depth: blend, brightness multiply, two-stage divide.
module hsv_gradient_position_color #(
	parameter int X_SPAN = 224
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [hgpc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [hgpc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	hgpc_in_if.sink                          pix_in,
	hgpc_out_if.source                       pix_out
);
	import hgpc_pkg::*;

	localparam int VDEN  = X_SPAN * 255;
	localparam int VDIV  = 2 * VDEN;
	localparam int VNUM_W = 25;

	cfg_t        cfg_q;
	prep_t       prep_s1;
	stage_en_t   en;
	div_en_t     hue_div_en, sat_div_en, val_div_en;
	logic        valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic [15:0] hprod_s2, snum_s3;
	logic [23:0] vmul_s4;
	hue_base_t   hbase_s4;
	logic [7:0]  hq_s4, sat_s5, val_s6;
	logic [7:0]  hue_s5, hue_s6, sat_s6;
	logic [VNUM_W-1:0] vnum;

	hgpc_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.wdata  (cfg_wdata),
		.cfg_q  (cfg_q)
	);

	// Advance each stage when it is empty or its successor moves
	always_comb begin
		en.s6 = !valid_s6 || pix_out.ready;
		en.s5 = !valid_s5 || en.s6;
		en.s4 = !valid_s4 || en.s5;
		en.s3 = !valid_s3 || en.s4;
		en.s2 = !valid_s2 || en.s3;
		en.s1 = !valid_s1 || en.s2;
	end

	// Map stage enables onto the two steps of each divider
	always_comb begin
		hue_div_en.a = en.s3;
		hue_div_en.b = en.s4;
		sat_div_en.a = en.s4;
		sat_div_en.b = en.s5;
		val_div_en.a = en.s5;
		val_div_en.b = en.s6;
	end

	assign pix_in.ready = en.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (en.s1) valid_s1 <= pix_in.valid;
			if (en.s2) valid_s2 <= valid_s1;
			if (en.s3) valid_s3 <= valid_s2;
			if (en.s4) valid_s4 <= valid_s3;
			if (en.s5) valid_s5 <= valid_s4;
			if (en.s6) valid_s6 <= valid_s5;
		end
	end

	hgpc_prep #(.X_SPAN(X_SPAN)) u_prep (
		.clk     (clk),
		.en      (en.s1),
		.led_x   (pix_in.led_x),
		.cfg     (cfg_q),
		.prep_s1 (prep_s1)
	);

	hgpc_blend #(.X_SPAN(X_SPAN)) u_blend (
		.clk        (clk),
		.en         (en),
		.prep_s1    (prep_s1),
		.brightness (cfg_q.global_brightness),
		.hprod_s2   (hprod_s2),
		.snum_s3    (snum_s3),
		.vmul_s4    (vmul_s4),
		.hbase_s4   (hbase_s4)
	);

	// Hue offset divide in stages 3 and 4
	hgpc_div_const #(.DIVISOR(X_SPAN), .NUM_W(16), .Q_W(8)) u_hue_div (
		.clk   (clk),
		.en    (hue_div_en),
		.num   (hprod_s2),
		.quo_q (hq_s4)
	);

	// Saturation divide in stages 4 and 5
	hgpc_div_const #(.DIVISOR(X_SPAN), .NUM_W(16), .Q_W(8)) u_sat_div (
		.clk   (clk),
		.en    (sat_div_en),
		.num   (snum_s3),
		.quo_q (sat_s5)
	);

	// Round half up: (2*num + den) / (2*den), divided in stages 5 and 6
	assign vnum = {vmul_s4, 1'b0} + VNUM_W'(VDEN);

	hgpc_div_const #(.DIVISOR(VDIV), .NUM_W(VNUM_W), .Q_W(8)) u_val_div (
		.clk   (clk),
		.en    (val_div_en),
		.num   (vnum),
		.quo_q (val_s6)
	);

	// Apply the hue offset modulo 256, then align hue and saturation with value
	always_ff @(posedge clk) begin
		if (en.s5) begin
			hue_s5 <= hbase_s4.neg ? (hbase_s4.a_hue - hq_s4) : (hbase_s4.a_hue + hq_s4);
		end
	end

	always_ff @(posedge clk) begin
		if (en.s6) begin
			hue_s6 <= hue_s5;
			sat_s6 <= sat_s5;
		end
	end

	assign pix_out.valid   = valid_s6;
	assign pix_out.out_hue = hue_s6;
	assign pix_out.out_sat = sat_s6;
	assign pix_out.out_val = val_s6;

	// An empty first stage never blocks the input
	a_empty_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> pix_in.ready)
		else $error("input blocked with stage 1 empty");

	// An item in stage 5 moves into stage 6 when stage 6 loads
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 && en.s6 |=> valid_s6)
		else $error("item lost between stages 5 and 6");

	// A full pipeline behind a blocked output takes nothing
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && valid_s3 && valid_s4 && valid_s5 && valid_s6
		&& !pix_out.ready |-> !pix_in.ready)
		else $error("input accepted into a full stalled pipeline");

	// The folded position never exceeds the span
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> prep_s1.n <= 8'(X_SPAN))
		else $error("folded position beyond span");

	// An accepted item occupies stage 1 on the next cycle
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		pix_in.valid && pix_in.ready |=> valid_s1)
		else $error("accepted item missing from stage 1");

endmodule
